FILE: rtl/itp_pkg.sv
// Shared types, codes and lookup functions for the infix-to-postfix converter.
package itp_pkg;

   // Operator codes as kept on the stack
   localparam logic [2:0] OPC_OPEN = 3'd0;
   localparam logic [2:0] OPC_ADD  = 3'd1;
   localparam logic [2:0] OPC_SUB  = 3'd2;
   localparam logic [2:0] OPC_MUL  = 3'd3;
   localparam logic [2:0] OPC_DIV  = 3'd4;
   localparam logic [2:0] OPC_POW  = 3'd5;

   // ASCII characters the converter reacts to
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_ADD   = 8'h2B;
   localparam logic [7:0] CH_SUB   = 8'h2D;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_POW   = 8'h5E;

   // Command queue depth between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      KIND_OTHER,
      KIND_OPEN,
      KIND_CLOSE,
      KIND_OP,
      KIND_END
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_OVERFLOW = 2'd1,
      ERR_CLOSE    = 2'd2,
      ERR_OPEN     = 2'd3
   } err_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_EVAL,
      ST_FINISH
   } eng_state_type;

   // Classified command handed from front to back
   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0]   code;
      logic [7:0]   ch;
   } cmd_type;

   function automatic logic [7:0] op_char(input logic [2:0] code);
      logic [7:0] ch;
      unique case (code)
         OPC_OPEN: ch = CH_OPEN;
         OPC_ADD:  ch = CH_ADD;
         OPC_SUB:  ch = CH_SUB;
         OPC_MUL:  ch = CH_MUL;
         OPC_DIV:  ch = CH_DIV;
         OPC_POW:  ch = CH_POW;
         default:  ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Priority of an operator sitting on the stack
   function automatic logic [2:0] stacked_pri(input logic [2:0] code);
      logic [2:0] pri;
      unique case (code)
         OPC_ADD, OPC_SUB: pri = 3'd2;
         OPC_MUL, OPC_DIV: pri = 3'd4;
         OPC_POW:          pri = 3'd5;
         default:          pri = 3'd0;
      endcase
      return pri;
   endfunction

   // Priority of an arriving operator
   function automatic logic [2:0] incoming_pri(input logic [2:0] code);
      logic [2:0] pri;
      unique case (code)
         OPC_ADD, OPC_SUB: pri = 3'd1;
         OPC_MUL, OPC_DIV: pri = 3'd3;
         default:          pri = 3'd6;
      endcase
      return pri;
   endfunction

endpackage

FILE: rtl/itp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/itp_front.sv
// Front end: accepts input beats, classifies each character into a command.
module itp_front
   import itp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   output logic       push_valid,
   input  logic       push_ready,
   output cmd_type    push_cmd
);

   logic    stage_valid_ff, stage_valid_in;
   cmd_type stage_cmd_ff, stage_cmd_in;
   cmd_type cmd_dec;
   logic    req_fire;

   // Classify the incoming character
   always_comb begin
      cmd_dec.kind = KIND_OTHER;
      cmd_dec.code = OPC_OPEN;
      cmd_dec.ch   = req_tdata;
      if (req_tlast) begin
         cmd_dec.kind = KIND_END;
      end else begin
         unique case (req_tdata)
            CH_OPEN:  cmd_dec.kind = KIND_OPEN;
            CH_CLOSE: cmd_dec.kind = KIND_CLOSE;
            CH_ADD: begin
               cmd_dec.kind = KIND_OP;
               cmd_dec.code = OPC_ADD;
            end
            CH_SUB: begin
               cmd_dec.kind = KIND_OP;
               cmd_dec.code = OPC_SUB;
            end
            CH_MUL: begin
               cmd_dec.kind = KIND_OP;
               cmd_dec.code = OPC_MUL;
            end
            CH_DIV: begin
               cmd_dec.kind = KIND_OP;
               cmd_dec.code = OPC_DIV;
            end
            CH_POW: begin
               cmd_dec.kind = KIND_OP;
               cmd_dec.code = OPC_POW;
            end
            default: cmd_dec.kind = KIND_OTHER;
         endcase
      end
   end

   // One-beat stage ahead of the queue
   assign req_tready = !stage_valid_ff || push_ready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      stage_cmd_in   = stage_cmd_ff;
      stage_valid_in = stage_valid_ff && !push_ready;
      if (req_fire) begin
         stage_cmd_in   = cmd_dec;
         stage_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_cmd_ff <= stage_cmd_in;
   end

   assign push_valid = stage_valid_ff;
   assign push_cmd   = stage_cmd_ff;

endmodule

FILE: rtl/itp_queue.sv
// Short command queue decoupling the front end from the stack engine.
module itp_queue
   import itp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    head_valid,
   output cmd_type head_cmd,
   input  logic    pop
);

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = (fill_ff != QCW'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QCW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/itp_engine.sv
// Back end: operator stack engine that executes commands and builds result beats.
module itp_engine
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  cmd_type    q_cmd,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [3:0] rsp_tuser,
   output logic       rsp_tlast
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   eng_state_type state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [7:0]    pend_char_ff, pend_char_in;
   err_code_type  err_ff, err_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_cvalid_ff, rsp_cvalid_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_done_ff, rsp_done_in;
   err_code_type  rsp_err_ff, rsp_err_in;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [2:0]    ram_wr_data, ram_rd_data;

   logic [CW-1:0] count_dec;
   logic          stack_full, stack_empty;
   logic          out_free;
   logic          top_open, top_higher;
   logic          pop_emit, pop_drop, eval_stall;
   logic          fin_done, fin_has, fin_stall;
   logic          out_load;

   itp_ram #(
      .WIDTH (3),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared decisions
   assign count_dec   = count_ff - CW'(1);
   assign stack_full  = (count_ff == CW'(STACK_DEPTH));
   assign stack_empty = (count_ff == '0);
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign top_open    = (ram_rd_data == OPC_OPEN);
   assign top_higher  = (stacked_pri(ram_rd_data) > incoming_pri(cmd_ff.code));

   always_comb begin
      pop_emit = 1'b0;
      pop_drop = 1'b0;
      case (cmd_ff.kind)
         KIND_END, KIND_CLOSE: begin
            pop_emit = !top_open;
            pop_drop = top_open;
         end
         KIND_OP: pop_emit = top_higher;
         default: begin
            pop_emit = 1'b0;
            pop_drop = 1'b0;
         end
      endcase
   end

   assign eval_stall = pop_emit && pend_valid_ff && !out_free;
   assign fin_done   = (cmd_ff.kind == KIND_END);
   assign fin_has    = pend_valid_ff || fin_done || (err_ff != ERR_NONE);
   assign fin_stall  = fin_has && !out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            unique case (cmd_ff.kind)
               KIND_OTHER: state_in = ST_FINISH;
               KIND_OPEN:  state_in = stack_full ? ST_FINISH : ST_IDLE;
               KIND_END, KIND_CLOSE, KIND_OP: begin
                  state_in = stack_empty ? ST_FINISH : ST_EVAL;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_EVAL: begin
            if (eval_stall) begin
               state_in = ST_EVAL;
            end else if (pop_emit || (pop_drop && fin_done)) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!fin_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and control outputs
   always_comb begin
      q_pop         = 1'b0;
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      err_in        = err_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[AW-1:0];
      ram_wr_data   = cmd_ff.code;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = count_dec[AW-1:0];
      out_load      = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_err_in    = rsp_err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               err_in = ERR_NONE;
            end
         end
         ST_DECIDE: begin
            unique case (cmd_ff.kind)
               KIND_OTHER: begin
                  pend_valid_in = 1'b1;
                  pend_char_in  = cmd_ff.ch;
               end
               KIND_OPEN: begin
                  if (stack_full) begin
                     err_in = ERR_OVERFLOW;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = OPC_OPEN;
                     count_in    = count_ff + CW'(1);
                  end
               end
               KIND_CLOSE: begin
                  if (stack_empty) begin
                     err_in = ERR_CLOSE;
                  end else begin
                     ram_rd_en = 1'b1;
                  end
               end
               KIND_OP: begin
                  // An empty stack always has room for the push
                  if (stack_empty) begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CW'(1);
                  end else begin
                     ram_rd_en = 1'b1;
                  end
               end
               default: begin
                  if (!stack_empty) begin
                     ram_rd_en = 1'b1;
                  end
               end
            endcase
         end
         ST_EVAL: begin
            if (!eval_stall) begin
               if (pop_emit) begin
                  count_in = count_dec;
                  // Previous pending char is not last: send it on
                  if (pend_valid_ff) begin
                     out_load      = 1'b1;
                     rsp_char_in   = pend_char_ff;
                     rsp_cvalid_in = 1'b1;
                     rsp_last_in   = 1'b0;
                     rsp_done_in   = 1'b0;
                     rsp_err_in    = ERR_NONE;
                  end
                  pend_valid_in = 1'b1;
                  pend_char_in  = op_char(ram_rd_data);
               end else if (pop_drop) begin
                  count_in = count_dec;
                  if (fin_done) begin
                     err_in = ERR_OPEN;
                  end
               end else if (stack_full) begin
                  err_in = ERR_OVERFLOW;
               end else begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CW'(1);
               end
            end
         end
         ST_FINISH: begin
            if (!fin_stall) begin
               pend_valid_in = 1'b0;
               if (fin_has) begin
                  out_load      = 1'b1;
                  rsp_char_in   = pend_valid_ff ? pend_char_ff : 8'h00;
                  rsp_cvalid_in = pend_valid_ff;
                  rsp_last_in   = 1'b1;
                  rsp_done_in   = fin_done;
                  rsp_err_in    = err_ff;
               end
            end
         end
         default: q_pop = 1'b0;
      endcase
   end

   // Output register
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         err_ff        <= ERR_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         err_ff        <= err_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      pend_char_ff <= pend_char_in;
      if (out_load) begin
         rsp_char_ff   <= rsp_char_in;
         rsp_cvalid_ff <= rsp_cvalid_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_done_ff   <= rsp_done_in;
         rsp_err_ff    <= rsp_err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = {rsp_err_ff, rsp_done_ff, rsp_cvalid_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending char left over between items");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_done_in) |-> stack_empty)
      else $error("expression finished with a non-empty stack");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_err_ff != ERR_NONE || rsp_done_ff)) |-> rsp_last_ff)
      else $error("status flags on a beat that is not last");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result beat overwritten before it was taken");

endmodule

FILE: rtl/infix_to_postfix_converter.sv
// Top level of the infix-to-postfix converter: front end, command queue, stack engine.
//
// Shunting-yard converter. Each req beat carries one character (req_tlast
// high ends the expression and flushes the stack). Operands and unknown
// characters pass straight through; + - * / ^ and parentheses go through an
// operator stack of STACK_DEPTH entries held in a RAM. Each rsp beat carries
// one postfix character or a status; rsp_tlast marks the final beat caused by
// an input beat, which also carries expression-done and any error code. Items
// that cause nothing (a push, a matched ')' with nothing to pop) give no beat.
// Flow: a front stage and a two-entry queue take input beats while the engine
// works. The engine accepts an item, then decides: a '(' is pushed, or sent to
// the closing state when the stack is full; a pass-through character goes to the
// closing state. An operator, ')' or end beat meeting an empty stack goes straight
// to the closing state; else each look at the top of stack is the registered RAM
// read, then the pop or push decision; the item ends in the closing state, with a
// further decide step if the stack runs empty. A result beat held back by rsp_tready
// stalls the engine on top of this. A push is a single RAM write. The stack
// needs no clearing after reset: only entries below the count are ever read.
module infix_to_postfix_converter
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   // Input channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,   // end_of_expr
   // Result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [3:0] rsp_tuser,   // [0] char_valid, [1] expr_done, [3:2] error_code
   output logic       rsp_tlast    // last_of_run
);

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    head_valid, head_pop;
   cmd_type head_cmd;

   itp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   itp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (head_pop)
   );

   itp_engine #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (head_valid),
      .q_cmd      (head_cmd),
      .q_pop      (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
